// File: rtl/lmdte_pkg.sv
// ----------------------------------------------------------------------------
// lmdte_pkg: shared types and constants of the line mark delta text encoder
// Character codes, status codes, controller/datapath command and status
// structs, and the base-32 digit character maps.
// ----------------------------------------------------------------------------
package lmdte_pkg;

    // result status codes
    localparam logic [1:0] ST_CHAR  = 2'd0;
    localparam logic [1:0] ST_LIMIT = 2'd1;
    localparam logic [1:0] ST_ORDER = 2'd2;

    // ASCII codes used by the encoder
    localparam logic [6:0] CH_COLON = 7'h3A;
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_LOW_A = 7'h61;
    localparam logic [6:0] CH_W     = 7'h77;
    localparam logic [6:0] CH_UP_A  = 7'h41;
    localparam logic [6:0] CH_PLUS  = 7'h2B;
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_LOW_V = 7'h76;
    localparam logic [6:0] CH_NINE  = 7'h39;

    // input action codes
    localparam logic ACT_START = 1'b0;

    // reset values
    localparam logic [15:0] MAX_LEN_RESET  = 16'd1023;
    localparam logic [15:0] TEXT_LEN_RESET = 16'd2;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_HDR_COLON,
        S_HDR_ZERO,
        S_STAT,
        S_DIGITS
    } state_t;

    // what the output register is loaded with
    typedef enum logic [2:0] {
        EM_NONE,
        EM_COLON,
        EM_ZERO,
        EM_STAT,
        EM_DIGIT
    } emit_sel_t;

    typedef struct packed {
        logic      latch;       // capture the accepted item
        logic      start_clear; // start of a new list
        logic      set_stop;    // length limit hit
        logic      commit;      // line accepted, update history
        emit_sel_t emit;
    } cmd_t;

    typedef struct packed {
        logic is_start;
        logic stopped;
        logic not_asc;
        logic over_limit;
        logic digit_last;
        logic out_free;
    } sts_t;

    // lowest digit: 0-9, a-v
    function automatic logic [6:0] low_char(input logic [4:0] d);
        if (d <= 5'd9)
            return CH_ZERO + {2'b00, d};
        else
            return CH_LOW_A + {2'b00, d - 5'd10};
    endfunction

    // upper digits: w-z, A-Z, +, -
    function automatic logic [6:0] high_char(input logic [4:0] d);
        if (d <= 5'd3)
            return CH_W + {2'b00, d};
        else if (d <= 5'd29)
            return CH_UP_A + {2'b00, d - 5'd4};
        else if (d == 5'd30)
            return CH_PLUS;
        else
            return CH_MINUS;
    endfunction

endpackage

// File: rtl/line_mark_delta_text_encoder.sv
// An item is accepted in S_IDLE, evaluated in S_EVAL, and its first result is
// loaded into the output register once that register is free. Each item gives
// 1..5 results for 24-bit lines; no new item is taken until all are loaded.
// One character per cycle leaves the output register while out_ready is high.
// Reset (rst_n, async, active low) clears history, sets length 2, limit 1023.
// ----------------------------------------------------------------------------
// line_mark_delta_text_encoder: top level
// Encodes ascending marked line numbers as base-32 gap text, one character
// per output item, with length limit and ordering status items.
// ----------------------------------------------------------------------------
module line_mark_delta_text_encoder #(
    parameter int LINE_BITS = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 action,
    input  logic [LINE_BITS-1:0] line_number,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [6:0]           char_code,
    output logic                 last,
    output logic [1:0]           status,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [15:0]          cfg_data
);

    lmdte_pkg::cmd_t cmd;
    lmdte_pkg::sts_t sts;

    // configuration register always takes writes
    assign cfg_ready = 1'b1;

    lmdte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lmdte_dp #(
        .LINE_BITS (LINE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .action      (action),
        .line_number (line_number),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .char_code   (char_code),
        .last        (last),
        .status      (status),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

// File: rtl/lmdte_ctrl.sv
// ----------------------------------------------------------------------------
// lmdte_ctrl: sequencing state machine
// Accepts one item, evaluates it, emits one result per cycle when out_free.
// ----------------------------------------------------------------------------
module lmdte_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lmdte_pkg::sts_t   sts,
    output lmdte_pkg::cmd_t   cmd
);

    lmdte_pkg::state_t state_reg;
    lmdte_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lmdte_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lmdte_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = lmdte_pkg::S_EVAL;
            end
            lmdte_pkg::S_EVAL:
            begin
                if (sts.is_start)
                    state_next = lmdte_pkg::S_HDR_COLON;
                else if (sts.stopped || sts.not_asc || sts.over_limit)
                    state_next = lmdte_pkg::S_STAT;
                else
                    state_next = lmdte_pkg::S_DIGITS;
            end
            lmdte_pkg::S_HDR_COLON:
            begin
                if (sts.out_free)
                    state_next = lmdte_pkg::S_HDR_ZERO;
            end
            lmdte_pkg::S_HDR_ZERO,
            lmdte_pkg::S_STAT:
            begin
                if (sts.out_free)
                    state_next = lmdte_pkg::S_IDLE;
            end
            lmdte_pkg::S_DIGITS:
            begin
                if (sts.out_free && sts.digit_last)
                    state_next = lmdte_pkg::S_IDLE;
            end
            default: state_next = lmdte_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready        = 1'b0;
        cmd.latch       = 1'b0;
        cmd.start_clear = 1'b0;
        cmd.set_stop    = 1'b0;
        cmd.commit      = 1'b0;
        cmd.emit        = lmdte_pkg::EM_NONE;
        unique case (state_reg)
            lmdte_pkg::S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
            end
            lmdte_pkg::S_EVAL:
            begin
                if (sts.is_start)
                    cmd.start_clear = 1'b1;
                else if (sts.stopped || sts.not_asc)
                    cmd.set_stop = 1'b0;
                else if (sts.over_limit)
                    cmd.set_stop = 1'b1;
                else
                    cmd.commit = 1'b1;
            end
            lmdte_pkg::S_HDR_COLON:
            begin
                if (sts.out_free)
                    cmd.emit = lmdte_pkg::EM_COLON;
            end
            lmdte_pkg::S_HDR_ZERO:
            begin
                if (sts.out_free)
                    cmd.emit = lmdte_pkg::EM_ZERO;
            end
            lmdte_pkg::S_STAT:
            begin
                if (sts.out_free)
                    cmd.emit = lmdte_pkg::EM_STAT;
            end
            lmdte_pkg::S_DIGITS:
            begin
                if (sts.out_free)
                    cmd.emit = lmdte_pkg::EM_DIGIT;
            end
            default: cmd.emit = lmdte_pkg::EM_NONE;
        endcase
    end

endmodule

// File: rtl/lmdte_dp.sv
// ----------------------------------------------------------------------------
// lmdte_dp: encoder datapath
// Line history, gap and digit count, length check, digit selection and the
// output register.
// ----------------------------------------------------------------------------
module lmdte_dp #(
    parameter int LINE_BITS = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 action,
    input  logic [LINE_BITS-1:0] line_number,
    input  logic                 cfg_valid,
    input  logic [15:0]          cfg_data,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [6:0]           char_code,
    output logic                 last,
    output logic [1:0]           status,
    input  lmdte_pkg::cmd_t      cmd,
    output lmdte_pkg::sts_t      sts
);

    localparam int ND    = (LINE_BITS + 4) / 5;  // most digits per line
    localparam int PAD_W = ND * 5;
    localparam int IDX_W = $clog2(ND + 1);

    // configuration and history
    logic [15:0]          max_len_reg;
    logic [LINE_BITS-1:0] prev_reg;
    logic                 have_prev_reg;
    logic [15:0]          text_len_reg;
    logic                 stopped_reg;

    // captured item
    logic                 act_reg;
    logic [LINE_BITS-1:0] line_reg;
    logic [LINE_BITS-1:0] gap_reg;
    logic                 nasc_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [1:0]           stat_reg;

    // output register
    logic                 out_valid_reg;
    logic [6:0]           char_reg;
    logic                 last_reg;
    logic [1:0]           status_reg;

    logic [LINE_BITS-1:0] gap_next;
    logic                 nasc_next;
    logic [PAD_W-1:0]     gap_pad;
    logic [IDX_W-1:0]     n_digits;
    logic [16:0]          len_sum;
    logic [4:0]           digit;
    logic                 out_free;

    // gap to previous line minus one, and the ordering test
    always_comb
    begin
        if (have_prev_reg)
            gap_next = line_number + ~prev_reg;
        else
            gap_next = line_number;
        nasc_next = have_prev_reg && (line_number <= prev_reg);
    end

    // digit count: highest nonzero 5-bit group index plus one, at least one
    assign gap_pad = PAD_W'(gap_reg);
    always_comb
    begin
        n_digits = IDX_W'(1);
        for (int g = 1; g < ND; g++)
        begin
            if (gap_pad[g*5 +: 5] != 5'd0)
                n_digits = IDX_W'(g + 1);
        end
    end

    assign len_sum  = {1'b0, text_len_reg} + 17'(n_digits);
    assign digit    = 5'(gap_pad >> (5 * idx_reg));
    assign out_free = !out_valid_reg || out_ready;

    assign sts.is_start   = (act_reg == lmdte_pkg::ACT_START);
    assign sts.stopped    = stopped_reg;
    assign sts.not_asc    = nasc_reg;
    assign sts.over_limit = len_sum > {1'b0, max_len_reg};
    assign sts.digit_last = (idx_reg == '0);
    assign sts.out_free   = out_free;

    // control and history registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg   <= lmdte_pkg::MAX_LEN_RESET;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            text_len_reg  <= lmdte_pkg::TEXT_LEN_RESET;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                max_len_reg <= cfg_data;
            if (cmd.start_clear)
            begin
                prev_reg      <= '0;
                have_prev_reg <= 1'b0;
                text_len_reg  <= lmdte_pkg::TEXT_LEN_RESET;
                stopped_reg   <= 1'b0;
            end
            else if (cmd.set_stop)
                stopped_reg <= 1'b1;
            else if (cmd.commit)
            begin
                prev_reg      <= line_reg;
                have_prev_reg <= 1'b1;
                text_len_reg  <= len_sum[15:0];
            end
            if (cmd.emit != lmdte_pkg::EM_NONE)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // item capture, digit index and status code
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            act_reg  <= action;
            line_reg <= line_number;
            gap_reg  <= gap_next;
            nasc_reg <= nasc_next;
        end
        if (cmd.commit)
            idx_reg <= n_digits - IDX_W'(1);
        else if (cmd.emit == lmdte_pkg::EM_DIGIT)
            idx_reg <= idx_reg - IDX_W'(1);
        if (cmd.start_clear || cmd.set_stop || cmd.commit)
            stat_reg <= lmdte_pkg::ST_LIMIT;
        else if (stopped_reg)
            stat_reg <= lmdte_pkg::ST_LIMIT;
        else
            stat_reg <= lmdte_pkg::ST_ORDER;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        case (cmd.emit)
            lmdte_pkg::EM_COLON:
            begin
                char_reg   <= lmdte_pkg::CH_COLON;
                last_reg   <= 1'b0;
                status_reg <= lmdte_pkg::ST_CHAR;
            end
            lmdte_pkg::EM_ZERO:
            begin
                char_reg   <= lmdte_pkg::CH_ZERO;
                last_reg   <= 1'b1;
                status_reg <= lmdte_pkg::ST_CHAR;
            end
            lmdte_pkg::EM_STAT:
            begin
                char_reg   <= 7'd0;
                last_reg   <= 1'b1;
                status_reg <= stat_reg;
            end
            lmdte_pkg::EM_DIGIT:
            begin
                char_reg   <= (idx_reg == '0) ? lmdte_pkg::low_char(digit)
                                              : lmdte_pkg::high_char(digit);
                last_reg   <= (idx_reg == '0);
                status_reg <= lmdte_pkg::ST_CHAR;
            end
            default:
            begin
                char_reg   <= char_reg;
                last_reg   <= last_reg;
                status_reg <= status_reg;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last      = last_reg;
    assign status    = status_reg;

endmodule

// File: rtl/lmdte_checker.sv
// ----------------------------------------------------------------------------
// lmdte_checker: port-level checks of the encoder
// Watches the output channel for stable stalled items, consistent status
// items and terminating final digits; attached to the top level by a bind.
// ----------------------------------------------------------------------------
module lmdte_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] char_code,
    input logic       last,
    input logic [1:0] status
);

    // a stalled output item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(char_code)
            && $stable(last) && $stable(status))
        else $error("output item changed while stalled");

    // status items are single, final and carry no character
    a_stat_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != lmdte_pkg::ST_CHAR) |-> last && (char_code == 7'd0))
        else $error("status item not final or carries a character");

    // only defined status codes appear
    a_stat_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == lmdte_pkg::ST_CHAR) || (status == lmdte_pkg::ST_LIMIT)
            || (status == lmdte_pkg::ST_ORDER))
        else $error("undefined status code");

    // the final character of an item is a terminating digit
    a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last && (status == lmdte_pkg::ST_CHAR) |->
            ((char_code >= lmdte_pkg::CH_ZERO) && (char_code <= lmdte_pkg::CH_NINE))
            || ((char_code >= lmdte_pkg::CH_LOW_A) && (char_code <= lmdte_pkg::CH_LOW_V)))
        else $error("final character is not a terminating digit");

endmodule

bind line_mark_delta_text_encoder lmdte_checker u_lmdte_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the line mark delta text encoder
// Items of start and marked-line actions are driven through the input
// channel. A predictor in the testbench tracks the previous line, the text
// length, the stopped flag and the length limit, and queues the expected
// characters and status items. The monitor checks every output item against
// that queue. The length limit is rewritten between phases while the block
// is idle.
// ----------------------------------------------------------------------------
module tb;

    localparam int  CLK_PERIOD     = 12;
    localparam int  HOLD_CYCLES    = 300;
    localparam int  WATCHDOG_LIMIT = 3000;
    localparam int  DRAIN_CYCLES   = 20;
    localparam logic ACT_MARK      = 1'b1;

    // receiver stall patterns
    localparam logic [1:0] RX_FREE    = 2'd0;
    localparam logic [1:0] RX_RANDOM  = 2'd1;
    localparam logic [1:0] RX_PATTERN = 2'd2;

    typedef struct packed {
        logic        act;
        logic [23:0] ln;
    } mark_item_t;

    typedef struct packed {
        logic [6:0] ch;
        logic       lst;
        logic [1:0] st;
    } text_item_t;

    // DUT signals
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        action = 1'b0;
    logic [23:0] line_number = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [6:0]  char_code;
    logic        last;
    logic [1:0]  status;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    // stimulus and expectations
    mark_item_t mark_q[$];
    text_item_t text_exp_q[$];
    int         n_queued = 0;
    int         n_accepted = 0;
    int         n_results = 0;
    int         n_chars = 0;
    int         n_limit = 0;
    int         n_order = 0;
    int         n_errors = 0;

    // encoder state as predicted
    logic [15:0] enc_max = lmdte_pkg::MAX_LEN_RESET;
    logic [23:0] enc_prev = '0;
    logic        enc_have_prev = 1'b0;
    logic [15:0] enc_len = lmdte_pkg::TEXT_LEN_RESET;
    logic        enc_stopped = 1'b0;

    // flow control knobs
    logic       tx_gapless = 1'b0;
    logic [1:0] rx_mode = RX_FREE;
    logic       hold_go = 1'b0;
    logic       hold_done;
    int         hold_cnt;
    logic [7:0] rx_cnt;
    int         burst_left = 0;
    int         gap_left = 0;
    mark_item_t tx_item;
    text_item_t got;
    text_item_t want;

    line_mark_delta_text_encoder #(
        .LINE_BITS (24)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .line_number (line_number),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .char_code   (char_code),
        .last        (last),
        .status      (status),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    // clock
    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // predict the text items of one accepted item and advance the state
    function automatic void encode_mark(input logic act, input logic [23:0] ln);
        logic [23:0] gap;
        logic [6:0]  digs [0:7];
        logic [4:0]  d;
        int          n;
        int          k;
        if (act == lmdte_pkg::ACT_START)
        begin
            enc_prev      = '0;
            enc_have_prev = 1'b0;
            enc_len       = lmdte_pkg::TEXT_LEN_RESET;
            enc_stopped   = 1'b0;
            text_exp_q.push_back('{lmdte_pkg::CH_COLON, 1'b0, lmdte_pkg::ST_CHAR});
            text_exp_q.push_back('{lmdte_pkg::CH_ZERO, 1'b1, lmdte_pkg::ST_CHAR});
            return;
        end
        // stopped wins over the ordering check
        if (enc_stopped)
        begin
            text_exp_q.push_back('{7'd0, 1'b1, lmdte_pkg::ST_LIMIT});
            return;
        end
        if (enc_have_prev && ln <= enc_prev)
        begin
            text_exp_q.push_back('{7'd0, 1'b1, lmdte_pkg::ST_ORDER});
            return;
        end
        gap = enc_have_prev ? ln - enc_prev - 24'd1 : ln;
        // digits collected lowest first
        n = 0;
        if (gap == '0)
        begin
            digs[0] = lmdte_pkg::CH_ZERO;
            n = 1;
        end
        else
        begin
            while (gap != '0)
            begin
                d = gap[4:0];
                if (n == 0)
                    digs[n] = (d < 5'd10) ? lmdte_pkg::CH_ZERO + 7'(d)
                                          : lmdte_pkg::CH_LOW_A + 7'(d - 5'd10);
                else if (d < 5'd4)
                    digs[n] = lmdte_pkg::CH_W + 7'(d);
                else if (d < 5'd30)
                    digs[n] = lmdte_pkg::CH_UP_A + 7'(d - 5'd4);
                else if (d == 5'd30)
                    digs[n] = lmdte_pkg::CH_PLUS;
                else
                    digs[n] = lmdte_pkg::CH_MINUS;
                n++;
                gap = gap >> 5;
            end
        end
        if (int'(enc_len) + n > int'(enc_max))
        begin
            enc_stopped = 1'b1;
            text_exp_q.push_back('{7'd0, 1'b1, lmdte_pkg::ST_LIMIT});
            return;
        end
        for (k = 0; k < n; k++)
            text_exp_q.push_back('{digs[n - 1 - k], (k == n - 1), lmdte_pkg::ST_CHAR});
        enc_len       = enc_len + 16'(n);
        enc_prev      = ln;
        enc_have_prev = 1'b1;
    endfunction

    // input driver: bursts with gaps, fed from mark_q
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            action      <= 1'b0;
            line_number <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                encode_mark(action, line_number);
                n_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0 && !tx_gapless)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (mark_q.size() != 0)
                begin
                    tx_item = mark_q.pop_front();
                    in_valid    <= 1'b1;
                    action      <= tx_item.act;
                    line_number <= tx_item.ln;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = $urandom_range(1, 7);
                    end
                    else
                        burst_left--;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern, plus one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_cnt    <= '0;
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            rx_cnt <= rx_cnt + 8'd1;
            if (hold_go && !hold_done)
            begin
                out_ready <= 1'b0;
                hold_cnt  <= hold_cnt + 1;
                if (hold_cnt >= HOLD_CYCLES - 1)
                    hold_done <= 1'b1;
            end
            else
            begin
                case (rx_mode)
                    RX_FREE:   out_ready <= 1'b1;
                    RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
                    default:   out_ready <= (rx_cnt[3:1] != 3'b111) &&
                                            ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // output monitor: compare against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got = '{char_code, last, status};
            n_results++;
            case (status)
                lmdte_pkg::ST_CHAR:  n_chars++;
                lmdte_pkg::ST_LIMIT: n_limit++;
                default:             n_order++;
            endcase
            if (text_exp_q.size() == 0)
            begin
                $error("unexpected output item: char_code %0h last %0d status %0d",
                       got.ch, got.lst, got.st);
                n_errors++;
            end
            else
            begin
                want = text_exp_q.pop_front();
                if (got.ch !== want.ch)
                begin
                    $error("char_code: expected %0h, got %0h", want.ch, got.ch);
                    n_errors++;
                end
                if (got.lst !== want.lst)
                begin
                    $error("last: expected %0d, got %0d", want.lst, got.lst);
                    n_errors++;
                end
                if (got.st !== want.st)
                begin
                    $error("status: expected %0d, got %0d", want.st, got.st);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    task automatic push_mark(input logic act, input logic [23:0] ln);
        mark_q.push_back('{act, ln});
        n_queued++;
    endtask

    // wait until every queued item is in and every result is out
    task automatic wait_idle();
        while (n_accepted != n_queued || text_exp_q.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_max_len(input logic [15:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        enc_max = v;
        @(negedge clk);
    endtask

    // random lists: mostly ascending lines, with restarts and noise
    task automatic gen_lists(input int count);
        int prev;
        int step;
        int pick;
        int k;
        prev = -1;
        push_mark(lmdte_pkg::ACT_START, '0);
        for (k = 1; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
            begin
                push_mark(lmdte_pkg::ACT_START, 24'($urandom));
                prev = -1;
            end
            else if (pick < 13)
                push_mark(ACT_MARK, 24'($urandom));
            else if (pick < 19 && prev >= 0)
                push_mark(ACT_MARK, 24'($urandom_range(0, prev)));
            else
            begin
                case ($urandom_range(0, 4))
                    0:       step = $urandom_range(1, 2);
                    1:       step = $urandom_range(1, 40);
                    2:       step = $urandom_range(1, 2000);
                    3:       step = $urandom_range(1, 1 << 20);
                    default: step = $urandom_range(1, (1 << 24) - 1);
                endcase
                if (prev + step > (1 << 24) - 1)
                begin
                    push_mark(lmdte_pkg::ACT_START, '0);
                    prev = -1;
                end
                else
                begin
                    prev = prev + step;
                    push_mark(ACT_MARK, 24'(prev));
                end
            end
        end
    endtask

    // main sequence
    initial
    begin
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset limit: lines before any start, gaps of one, two, four and five
        // digits, out-of-order lines, largest line number
        rx_mode <= RX_RANDOM;
        push_mark(ACT_MARK, 24'd0);
        push_mark(ACT_MARK, 24'd5);
        push_mark(lmdte_pkg::ACT_START, 24'hFFFFFF);
        push_mark(ACT_MARK, 24'd0);
        push_mark(ACT_MARK, 24'd1);
        push_mark(ACT_MARK, 24'd1);
        push_mark(ACT_MARK, 24'd0);
        push_mark(ACT_MARK, 24'd33);
        push_mark(ACT_MARK, 24'd66);
        push_mark(lmdte_pkg::ACT_START, '0);
        push_mark(ACT_MARK, 24'hFFFFFF);
        push_mark(ACT_MARK, 24'hFFFFFF);
        push_mark(ACT_MARK, 24'd0);
        push_mark(lmdte_pkg::ACT_START, '0);
        push_mark(ACT_MARK, 24'h0FFFFF);
        wait_idle();

        // limit of two: first line stops the list, stop before ordering
        write_max_len(16'd2);
        push_mark(lmdte_pkg::ACT_START, '0);
        push_mark(ACT_MARK, 24'd3);
        push_mark(ACT_MARK, 24'd10);
        push_mark(ACT_MARK, 24'd0);
        wait_idle();

        // limit below the header length
        write_max_len(16'd1);
        push_mark(lmdte_pkg::ACT_START, '0);
        push_mark(ACT_MARK, 24'd0);
        wait_idle();

        // text filled exactly to the limit, then two more lines
        write_max_len(16'd8);
        push_mark(lmdte_pkg::ACT_START, '0);
        push_mark(ACT_MARK, 24'd0);
        push_mark(ACT_MARK, 24'd40);
        push_mark(ACT_MARK, 24'd41);
        push_mark(ACT_MARK, 24'd100);
        push_mark(ACT_MARK, 24'd101);
        push_mark(ACT_MARK, 24'd200);
        wait_idle();

        // largest limit, with a long receiver hold-off
        write_max_len(16'hFFFF);
        rx_mode <= RX_RANDOM;
        hold_go <= 1'b1;
        gen_lists(80);
        wait_idle();

        // small limits, sender without gaps
        write_max_len(16'($urandom_range(16, 80)));
        tx_gapless <= 1'b1;
        rx_mode    <= RX_PATTERN;
        gen_lists(75);
        wait_idle();

        // limit from 2 to 65535, receiver always ready
        write_max_len(16'($urandom_range(2, 65535)));
        tx_gapless <= 1'b0;
        rx_mode    <= RX_FREE;
        gen_lists(75);
        wait_idle();

        // back to the reset limit
        write_max_len(lmdte_pkg::MAX_LEN_RESET);
        rx_mode <= RX_RANDOM;
        gen_lists(75);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (text_exp_q.size() != 0)
        begin
            $error("%0d expected output items never arrived", text_exp_q.size());
            n_errors++;
        end
        $display("Covered %0d input items and %0d output items", n_accepted, n_results);
        $display("  %0d characters, %0d length-limit, %0d out-of-order status items",
                 n_chars, n_limit, n_order);
        if (n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: sim.f
rtl/lmdte_pkg.sv
rtl/lmdte_ctrl.sv
rtl/lmdte_dp.sv
rtl/line_mark_delta_text_encoder.sv
rtl/lmdte_checker.sv
tb/tb.sv
